FILE: rtl/apm_pkg.sv
// ============================================================================
// apm_pkg: shared types and constants for the audio peak meter
// Holds default sizes, dB conversion constants, IEC scale breakpoints,
// the controller state type and the controller-to-datapath command bundle.
// ============================================================================
package apm_pkg;

    // Default sizes handed to the top level parameters
    localparam int NUM_CHANNELS_DEF   = 2;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int LOG_TABLE_BITS_DEF = 6;

    // Result field widths
    localparam int LEVEL_W = 15;
    localparam int DB_W    = 16;

    // 20*log10(2) in Q.16 and the shift amount for the >>24 rescale
    localparam int             DB_K_W = 19;
    localparam logic [DB_K_W-1:0] DB_K = DB_K_W'(394566);
    localparam int             DB_SHIFT = 24;

    // IEC scale breakpoints, as dB magnitudes in Q8.8
    localparam logic [15:0] IEC_M70 = 16'd17920;
    localparam logic [15:0] IEC_M60 = 16'd15360;
    localparam logic [15:0] IEC_M50 = 16'd12800;
    localparam logic [15:0] IEC_M40 = 16'd10240;
    localparam logic [15:0] IEC_M30 = 16'd7680;
    localparam logic [15:0] IEC_M20 = 16'd5120;

    // IEC scale segment offsets, 0..100 in 1/256 units
    localparam logic [15:0] IEC_OFS_60 = 16'd640;
    localparam logic [15:0] IEC_OFS_50 = 16'd1920;
    localparam logic [15:0] IEC_OFS_40 = 16'd3840;
    localparam logic [15:0] IEC_OFS_30 = 16'd7680;
    localparam logic [15:0] IEC_OFS_20 = 16'd12800;
    localparam logic [15:0] IEC_FULL   = 16'd25600;

    // Magnitude used for the dB floor (-128 dB)
    localparam logic [15:0] DB_FLOOR_MAG = 16'h8000;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_LOD,
        ST_MUL,
        ST_FIN
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch the accepted item
        logic update;   // compare magnitude and update the held peak
        logic lod;      // fetch peak, clear it, leading-one detect, table read
        logic mul;      // dB product
        logic fin;      // rescale, IEC map, load result register
    } cmd_t;

endpackage

FILE: rtl/apm_in_if.sv
// ============================================================================
// apm_in_if: item channel of the peak meter
// valid/ready handshake carrying one update or read request.
// ============================================================================
interface apm_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic                   direction;
    logic                   channel;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, func, direction, channel, sample, input ready);
    modport sink   (input valid, func, direction, channel, sample, output ready);
endinterface

FILE: rtl/apm_out_if.sv
// ============================================================================
// apm_out_if: result channel of the peak meter
// valid/ready handshake carrying the IEC level and the dBFS peak.
// ============================================================================
interface apm_out_if;
    logic                               valid;
    logic                               ready;
    logic [apm_pkg::LEVEL_W-1:0]        meter_level;
    logic signed [apm_pkg::DB_W-1:0]    peak_db;

    modport source (output valid, meter_level, peak_db, input ready);
    modport sink   (input valid, meter_level, peak_db, output ready);
endinterface

FILE: rtl/apm_ctrl.sv
// ============================================================================
// apm_ctrl: sequencing controller of the peak meter
// Accepts items, steps the datapath through update or read, and owns the
// result valid flag.
// ============================================================================
module apm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_func,
    output logic          in_ready,
    input  logic          out_ready,
    output logic          out_valid,
    output apm_pkg::cmd_t cmd
);
    import apm_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_func ? ST_LOD : ST_UPD;
                end
            end
            ST_UPD:  state_next = ST_IDLE;
            ST_LOD:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_UPD:  cmd.update = 1'b1;
            ST_LOD:  cmd.lod    = 1'b1;
            ST_MUL:  cmd.mul    = 1'b1;
            ST_FIN:  cmd.fin    = slot_free;
            default: cmd        = '0;
        endcase
    end

    // Result valid: set on load, cleared on transfer
    assign out_valid_next = cmd.fin || (out_valid_reg && !out_ready);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/apm_datapath.sv
// ============================================================================
// apm_datapath: peak store, log conversion and IEC scale
// Holds one peak per direction and channel, converts a read peak to Q8.8
// dBFS through a leading-one detector and a log2 ROM, then maps to IEC.
// ============================================================================
module apm_datapath #(
    parameter int NUM_CHANNELS   = 2,
    parameter int SAMPLE_BITS    = 24,
    parameter int LOG_TABLE_BITS = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  apm_pkg::cmd_t                   cmd,
    input  logic                            direction,
    input  logic                            channel,
    input  logic [SAMPLE_BITS-1:0]          sample,
    output logic [apm_pkg::LEVEL_W-1:0]     meter_level,
    output logic signed [apm_pkg::DB_W-1:0] peak_db
);
    import apm_pkg::*;

    localparam int MW        = SAMPLE_BITS - 1;       // magnitude width
    localparam int PW        = $clog2(MW + 1);        // leading-one position width
    localparam int T         = LOG_TABLE_BITS;
    localparam int TBL_DEPTH = 1 << T;
    localparam int W         = MW + T;                // normalizer width
    localparam int ENTRIES   = 2 * NUM_CHANNELS;
    localparam int SLW       = $clog2(ENTRIES);
    localparam int NLW       = PW + 16;               // -log2 in Q.16
    localparam int PRW       = NLW + DB_K_W;          // dB product width
    localparam logic [PW-1:0] PTOP = PW'(MW - 1);
    localparam logic [PW-1:0] PFS  = PW'(MW);         // full-scale position

    typedef logic [15:0] rom_t [TBL_DEPTH];

    // log2(1 + i/2^T) in Q0.16 by bit-serial squaring, truncated
    function automatic logic [15:0] log2_frac_q16(input int i);
        logic [63:0] x;
        logic [15:0] r;
        x = (64'd1 << 30) + (64'(i) << (30 - T));
        r = '0;
        for (int k = 0; k < 16; k++)
        begin
            x = (x * x) >> 30;
            r = {r[14:0], 1'b0};
            if (x >= (64'd1 << 31))
            begin
                r[0] = 1'b1;
                x    = x >> 1;
            end
        end
        return r;
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            r[i] = log2_frac_q16(i);
        end
        return r;
    endfunction

    localparam rom_t LOG_ROM = build_rom();

    // Captured item
    logic                   dir_reg;
    logic                   ch_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    // Peak store
    logic [MW-1:0] store_reg [ENTRIES];

    // Pipeline registers
    logic [PW-1:0]  p_reg;
    logic           zero_reg;
    logic           neg_reg;
    logic [15:0]    tbl_reg;
    logic [PRW-1:0] prod_reg;
    logic [LEVEL_W-1:0]     level_reg;
    logic signed [DB_W-1:0] db_reg;

    logic           ok;
    logic [SLW-1:0] slot;
    logic [SAMPLE_BITS-1:0] neg_s;
    logic [MW-1:0]  mag;
    logic [MW-1:0]  peak;
    logic [PW-1:0]  p;
    logic [W-1:0]   norm;
    logic [T-1:0]   idx;
    logic [NLW-1:0] scaled;
    logic [NLW-1:0] diff;
    logic           neg_l;
    logic [PRW:0]   rnd;
    logic           floor_db;
    logic [15:0]    a;
    logic [15:0]    t;
    logic [15:0]    lvl;

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dir_reg    <= direction;
            ch_reg     <= channel;
            sample_reg <= sample;
        end
    end

    // Slot select; an unsupported channel touches nothing
    always_comb
    begin
        ok   = int'(ch_reg) < NUM_CHANNELS;
        slot = SLW'(int'(dir_reg) * NUM_CHANNELS + (ok ? int'(ch_reg) : 0));
    end

    // Sample magnitude, most negative value saturates
    always_comb
    begin
        neg_s = (~sample_reg) + SAMPLE_BITS'(1);
        if (!sample_reg[SAMPLE_BITS-1])
        begin
            mag = sample_reg[MW-1:0];
        end
        else if (sample_reg == {1'b1, {MW{1'b0}}})
        begin
            mag = {MW{1'b1}};
        end
        else
        begin
            mag = neg_s[MW-1:0];
        end
    end

    // Peak store: max on update, clear on read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (cmd.update && ok && (mag > store_reg[slot]))
        begin
            store_reg[slot] <= mag;
        end
        else if (cmd.lod && ok)
        begin
            store_reg[slot] <= '0;
        end
    end

    // Leading one and table index
    always_comb
    begin
        peak = ok ? store_reg[slot] : '0;
        p    = '0;
        for (int b = 0; b < MW; b++)
        begin
            if (peak[b])
            begin
                p = PW'(b);
            end
        end
        norm = {peak, {T{1'b0}}} << (PTOP - p);
        idx  = norm[W-2 -: T];
    end

    // Stage 1: position, zero flag, ROM read
    always_ff @(posedge clk)
    begin
        if (cmd.lod)
        begin
            p_reg    <= p;
            zero_reg <= (peak == '0);
            tbl_reg  <= LOG_ROM[idx];
        end
    end

    // -log2 in Q.16, full scale sits one octave above the top magnitude bit;
    // a negative value lands on the floor
    always_comb
    begin
        scaled = {PFS - p_reg, 16'h0000};
        neg_l  = scaled < NLW'(tbl_reg);
        diff   = scaled - NLW'(tbl_reg);
    end

    // Stage 2: dB product
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PRW'(diff) * PRW'(DB_K);
            neg_reg  <= neg_l;
        end
    end

    // Round, rescale and floor; a is the dB magnitude
    always_comb
    begin
        rnd      = {1'b0, prod_reg} + ((PRW+1)'(1) << (DB_SHIFT - 1));
        floor_db = zero_reg || neg_reg || (|rnd[PRW:DB_SHIFT+15]);
        a        = floor_db ? DB_FLOOR_MAG : {1'b0, rnd[DB_SHIFT+14:DB_SHIFT]};
    end

    // IEC piecewise-linear scale
    always_comb
    begin
        t   = '0;
        lvl = '0;
        if (a > IEC_M70)
        begin
            lvl = '0;
        end
        else if (a > IEC_M60)
        begin
            t   = IEC_M70 - a;
            lvl = t >> 2;
        end
        else if (a > IEC_M50)
        begin
            t   = IEC_M60 - a;
            lvl = (t >> 1) + IEC_OFS_60;
        end
        else if (a > IEC_M40)
        begin
            t   = (IEC_M50 - a) * 16'd3;
            lvl = (t >> 2) + IEC_OFS_50;
        end
        else if (a > IEC_M30)
        begin
            t   = (IEC_M40 - a) * 16'd3;
            lvl = (t >> 1) + IEC_OFS_40;
        end
        else if (a > IEC_M20)
        begin
            t   = (IEC_M30 - a) << 1;
            lvl = t + IEC_OFS_30;
        end
        else if (a != '0)
        begin
            t   = (IEC_M20 - a) * 16'd5;
            lvl = (t >> 1) + IEC_OFS_20;
        end
        else
        begin
            lvl = IEC_FULL;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            level_reg <= lvl[LEVEL_W-1:0];
            db_reg    <= $signed((~a) + 16'd1);
        end
    end

    assign meter_level = level_reg;
    assign peak_db     = db_reg;

endmodule

FILE: rtl/audio_peak_meter_iec_scale.sv
// ============================================================================
// audio_peak_meter_iec_scale: held-peak meter with dBFS and IEC scale output
// Keeps a peak magnitude per direction and channel; a read returns it as
// Q8.8 dBFS and as an IEC level 0..25600, then clears it.
// ============================================================================
//
//  Channel  Dir  Payload                                  Transfers
//  item     in   func, direction, channel, sample         every request
//  meter    out  meter_level, peak_db                     one per read
//
//  An update runs transfer, then compare and write.
//  A read runs transfer, peak fetch with leading-one detect and log ROM
//  read, dB multiply, rescale with IEC map into the result register.
//  The read holds in its last step while the result register is still full.
//  Reset clears the peak store at once; no sweep follows it.
//
module audio_peak_meter_iec_scale #(
    parameter int NUM_CHANNELS   = apm_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS    = apm_pkg::SAMPLE_BITS_DEF,
    parameter int LOG_TABLE_BITS = apm_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    apm_in_if.sink     item,
    apm_out_if.source  meter
);
    import apm_pkg::*;

    cmd_t cmd;

    // Controller
    apm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_func   (item.func),
        .in_ready  (item.ready),
        .out_ready (meter.ready),
        .out_valid (meter.valid),
        .cmd       (cmd)
    );

    // Datapath
    apm_datapath #(
        .NUM_CHANNELS   (NUM_CHANNELS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .direction   (item.direction),
        .channel     (item.channel),
        .sample      (item.sample),
        .meter_level (meter.meter_level),
        .peak_db     (meter.peak_db)
    );

endmodule

FILE: sim/tb.sv
// ============================================================================
// tb: self-checking testbench for the audio peak meter with IEC scale
// Drives update and read requests over the item channel, predicts every
// meter transfer with an independent held-peak, dBFS and IEC scale model,
// and checks each result field by field under random source and sink stalls.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apm_pkg::*;

    localparam int SAMPLE_W    = 24;
    localparam int MAG_W       = SAMPLE_W - 1;
    localparam int CHANNELS    = 2;
    localparam int SLOTS       = 2 * CHANNELS;
    localparam int LUT_BITS    = 6;
    localparam int HOLD_CYCLES = 96;

    // dB per octave in Q.16 and the floor code for an empty peak
    localparam longint unsigned OCTAVE_DB_Q16 = 394566;
    localparam int              DBFS_FLOOR    = -32768;
    localparam int              LEVEL_FULL    = 25600;

    typedef enum logic {
        FN_UPDATE = 1'b0,
        FN_READ   = 1'b1
    } meter_func_e;

    typedef enum logic {
        DIR_INPUT  = 1'b0,
        DIR_OUTPUT = 1'b1
    } meter_dir_e;

    typedef struct packed {
        logic [LEVEL_W-1:0]       level;
        logic signed [DB_W-1:0]   db;
    } meter_result_t;

    logic clk = 1'b0;
    logic rst_n;

    apm_in_if #(.SAMPLE_BITS(SAMPLE_W)) item_if ();
    apm_out_if                          meter_if ();

    audio_peak_meter_iec_scale #(
        .NUM_CHANNELS   (CHANNELS),
        .SAMPLE_BITS    (SAMPLE_W),
        .LOG_TABLE_BITS (LUT_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if),
        .meter (meter_if)
    );

    // Predictor state
    logic [15:0]    octave_lut [1 << LUT_BITS];
    logic [MAG_W-1:0] held_peak [SLOTS];
    meter_result_t  meter_q [$];
    meter_result_t  want_res;

    int  err_count   = 0;
    bit  src_idle_en = 1'b1;
    bit  snk_idle_en = 1'b1;
    bit  hold_req    = 1'b0;

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // log2(1 + i/2^LUT_BITS) in Q0.16 by repeated squaring, truncated
    function automatic logic [15:0] octave_frac(int unsigned i);
        longint unsigned x;
        logic [15:0]     r;
        x = (64'd1 << 30) + (64'(i) << (30 - LUT_BITS));
        r = '0;
        for (int k = 0; k < 16; k++)
        begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd1 << 31))
            begin
                r[0] = 1'b1;
                x    = x >> 1;
            end
        end
        return r;
    endfunction

    // |sample|, most negative code clamps to full scale minus one
    function automatic logic [MAG_W-1:0] sample_mag(logic signed [SAMPLE_W-1:0] s);
        if (s == {1'b1, {MAG_W{1'b0}}})
            return {MAG_W{1'b1}};
        else if (s < 0)
            return MAG_W'(-s);
        else
            return MAG_W'(s);
    endfunction

    // Held peak to Q8.8 dBFS via leading one plus fraction table
    function automatic int peak_dbfs(logic [MAG_W-1:0] m);
        int              lead;
        longint unsigned frac;
        longint unsigned idx;
        longint unsigned neg_l;
        longint unsigned mag;
        if (m == '0)
            return DBFS_FLOOR;
        lead = 0;
        for (int b = 0; b < MAG_W; b++)
            if (m[b])
                lead = b;
        frac = 64'(m) - (64'd1 << lead);
        if (lead >= LUT_BITS)
            idx = frac >> (lead - LUT_BITS);
        else
            idx = frac << (LUT_BITS - lead);
        idx   = idx & ((64'd1 << LUT_BITS) - 1);
        neg_l = 64'(MAG_W - lead) * 65536 - 64'(octave_lut[idx]);
        mag   = (neg_l * OCTAVE_DB_Q16 + (64'd1 << 23)) >> 24;
        if (mag >= 32768)
            return DBFS_FLOOR;
        return -int'(mag);
    endfunction

    // Piecewise-linear IEC scale, 0..100 in 1/256 units
    function automatic int iec_meter(int d);
        if (d < -17920) return 0;
        if (d < -15360) return (d + 17920) / 4;
        if (d < -12800) return (d + 15360) / 2 + 640;
        if (d < -10240) return ((d + 12800) * 3) / 4 + 1920;
        if (d < -7680)  return ((d + 10240) * 3) / 2 + 3840;
        if (d < -5120)  return (d + 7680) * 2 + 7680;
        if (d < 0)      return ((d + 5120) * 5) / 2 + 12800;
        return LEVEL_FULL;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && meter_if.valid && meter_if.ready)
        begin
            if (meter_q.size() == 0)
                report_mismatch($sformatf("meter transfer with none expected: level %0d db %0d",
                                          meter_if.meter_level, meter_if.peak_db));
            else
            begin
                want_res = meter_q.pop_front();
                if (meter_if.meter_level !== want_res.level)
                    report_mismatch($sformatf("meter_level got %0d expected %0d",
                                              meter_if.meter_level, want_res.level));
                if (meter_if.peak_db !== want_res.db)
                    report_mismatch($sformatf("peak_db got %0d expected %0d",
                                              meter_if.peak_db, want_res.db));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink side: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : sink_ready
        int stall_left;
        stall_left = 0;
        meter_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                meter_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                meter_if.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                meter_if.ready <= 1'b0;
                stall_left--;
            end
            else if (snk_idle_en && $urandom_range(0, 4) == 0)
            begin
                meter_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
                meter_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------

    // Offer one request, wait for its transfer, then update the prediction
    task automatic send_item(meter_func_e fn, meter_dir_e dir, logic ch,
                             logic signed [SAMPLE_W-1:0] smp);
        int            slot;
        int            db;
        logic [MAG_W-1:0] mag;
        meter_result_t res;
        item_if.valid     <= 1'b1;
        item_if.func      <= fn;
        item_if.direction <= dir;
        item_if.channel   <= ch;
        item_if.sample    <= smp;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        slot = int'(dir) * CHANNELS + int'(ch);
        if (fn == FN_UPDATE)
        begin
            mag = sample_mag(smp);
            if (mag > held_peak[slot])
                held_peak[slot] = mag;
        end
        else
        begin
            db              = peak_dbfs(held_peak[slot]);
            held_peak[slot] = '0;
            res.level       = LEVEL_W'(iec_meter(db));
            res.db          = DB_W'(db);
            meter_q.push_back(res);
        end
        // optional source gap after the transfer
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        while (meter_q.size() != 0)
            @(posedge clk);
    endtask

    // Sample with a random bit length so every dB segment is reached
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        logic [SAMPLE_W-1:0] r;
        int                  nb;
        case ($urandom_range(0, 39))
            0: return {1'b1, {MAG_W{1'b0}}};
            1: return {1'b0, {MAG_W{1'b1}}};
            default:
            begin
                nb = $urandom_range(0, SAMPLE_W);
                r  = SAMPLE_W'($urandom);
                if (nb < SAMPLE_W)
                begin
                    r = r & ((SAMPLE_W'(1) << nb) - SAMPLE_W'(1));
                    if ($urandom_range(0, 1))
                        r = -r;
                end
                return r;
            end
        endcase
    endfunction

    task automatic send_random(int read_pct);
        meter_func_e fn;
        fn = ($urandom_range(0, 99) < read_pct) ? FN_READ : FN_UPDATE;
        send_item(fn, meter_dir_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  rand_sample());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every slot reads as an empty peak after reset
    task automatic test_reset_state();
        for (int s = 0; s < SLOTS; s++)
            send_item(FN_READ, meter_dir_e'(s / CHANNELS), 1'(s % CHANNELS), '1);
    endtask

    // Sample extremes, each written then read back on a rotating slot
    task automatic test_extremes();
        logic signed [SAMPLE_W-1:0] vals [8];
        vals = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'sh000001,
                 24'shFFFFFF, 24'sh400000, 24'sh010000, 24'sh000800};
        for (int i = 0; i < 8; i++)
        begin
            send_item(FN_UPDATE, meter_dir_e'(i[1]), i[0], vals[i]);
            send_item(FN_READ, meter_dir_e'(i[1]), i[0], ~vals[i]);
        end
    endtask

    // Peak keeps the largest magnitude, a read clears it
    task automatic test_peak_hold();
        send_item(FN_UPDATE, DIR_OUTPUT, 1'b1, 24'sd1000);
        send_item(FN_UPDATE, DIR_OUTPUT, 1'b1, -24'sd5000);
        send_item(FN_UPDATE, DIR_OUTPUT, 1'b1, 24'sd20);
        send_item(FN_READ, DIR_OUTPUT, 1'b1, '0);
        send_item(FN_READ, DIR_OUTPUT, 1'b1, '0);
    endtask

    // Sink holds off while requests keep coming, then a full drain
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_random(66);
        item_if.valid <= 1'b0;
        wait_drain();
    endtask

    // Random mix in chunks, idling switched per chunk
    task automatic test_random_mix();
        for (int c = 0; c < 8; c++)
        begin
            src_idle_en = (c % 3) != 1;
            snk_idle_en = (c % 3) != 2;
            for (int i = 0; i < 110; i++)
                send_random(30);
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_streaming();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        for (int i = 0; i < 150; i++)
            send_random(30);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             <= 1'b0;
        item_if.valid     <= 1'b0;
        item_if.func      <= FN_UPDATE;
        item_if.direction <= DIR_INPUT;
        item_if.channel   <= 1'b0;
        item_if.sample    <= '0;
        for (int i = 0; i < (1 << LUT_BITS); i++)
            octave_lut[i] = octave_frac(i);
        for (int s = 0; s < SLOTS; s++)
            held_peak[s] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_extremes();
        test_peak_hold();
        test_backpressure();
        test_random_mix();
        test_streaming();

        item_if.valid <= 1'b0;
        wait_drain();
        repeat (8) @(posedge clk);
        if (err_count == 0 && meter_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: audio_peak_meter_iec_scale.f
rtl/apm_pkg.sv
rtl/apm_in_if.sv
rtl/apm_out_if.sv
rtl/apm_ctrl.sv
rtl/apm_datapath.sv
rtl/audio_peak_meter_iec_scale.sv
sim/tb.sv
